### rtl/pgs_pkg.sv
package pgs_pkg;

	localparam int UNIFORM_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_OFFSET  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_SCALE = CFG_IDX_W'(1);

	localparam int MEAN_W   = 32;
	localparam int SCALE_W  = 31;
	localparam int SAMPLE_W = 32;
	localparam logic signed [MEAN_W-1:0] MEAN_RESET  = '0;
	localparam logic [SCALE_W-1:0]       SCALE_RESET = SCALE_W'(65536);

	localparam int MANT_W    = 32;
	localparam int E_W       = 6;
	localparam int FRAC_W    = 32;
	localparam int LN_W      = 41;
	localparam int ROOT_SH   = 20;
	localparam int ROOT_IN_W = LN_W + ROOT_SH + 1;
	localparam int R_W       = 31;
	localparam int ROUND_SH  = 24;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef struct packed {
		logic push;
		logic drop;
	} front_stat_t;

endpackage

### rtl/pgs_front.sv
module pgs_front import pgs_pkg::*; #(
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [UNIFORM_BITS-1:0]   uniform_first,
	input  logic [UNIFORM_BITS-1:0]   uniform_second,
	output front_stat_t               stat,
	output logic signed [UNIFORM_BITS:0] w1,
	output logic signed [UNIFORM_BITS:0] w2,
	output logic [MANT_W-1:0]         mant,
	output logic [E_W-1:0]            expo
);
	localparam int UB     = UNIFORM_BITS;
	localparam int SW     = 2 * UB;
	localparam int NW     = (SW > MANT_W) ? SW : MANT_W;
	localparam int NSH    = $clog2(NW);
	localparam int LZ_OFF = NW - SW + 1;
	localparam logic signed [UB:0] HALF = {2'b01, {(UB-1){1'b0}}};

	logic                 v_s1, v_s2;
	logic signed [UB:0]   w1_s1, w2_s1, w1_s2, w2_s2;
	logic [UB-1:0]        mag1, mag2;
	logic [SW-1:0]        sq1_s2, sq2_s2, sum;
	logic                 rej, drop_q;

	logic                 v_sn   [NSH+1];
	logic [NW-1:0]        norm_sn[NSH+1];
	logic [NSH-1:0]       lz_sn  [NSH+1];
	logic signed [UB:0]   w1_sn  [NSH+1];
	logic signed [UB:0]   w2_sn  [NSH+1];

	always_comb begin
		mag1 = w1_s1[UB] ? UB'(-w1_s1) : UB'(w1_s1);
		mag2 = w2_s1[UB] ? UB'(-w2_s1) : UB'(w2_s1);
		sum  = sq1_s2 + sq2_s2;
		rej  = (sum == '0) || (sum[SW-1:SW-2] != 2'b00);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_sn[0]  <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			v_s1     <= take;
			v_s2     <= v_s1;
			v_sn[0]  <= v_s2 & ~rej;
			drop_q   <= v_s2 & rej;
		end
	end

	always_ff @(posedge clk) begin
		w1_s1      <= $signed({1'b0, uniform_first}) - HALF;
		w2_s1      <= $signed({1'b0, uniform_second}) - HALF;
		sq1_s2     <= SW'(mag1) * SW'(mag1);
		sq2_s2     <= SW'(mag2) * SW'(mag2);
		w1_s2      <= w1_s1;
		w2_s2      <= w2_s1;
		norm_sn[0] <= NW'(sum);
		lz_sn[0]   <= '0;
		w1_sn[0]   <= w1_s2;
		w2_sn[0]   <= w2_s2;
	end

	// leading zero removal, halving the shift each stage
	for (genvar k = 1; k <= NSH; k++) begin : g_norm
		localparam int SH = 2 ** (NSH - k);
		logic zero_top;
		assign zero_top = (norm_sn[k-1][NW-1 -: SH] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else begin
				v_sn[k] <= v_sn[k-1];
			end
		end

		always_ff @(posedge clk) begin
			norm_sn[k] <= zero_top ? (norm_sn[k-1] << SH) : norm_sn[k-1];
			lz_sn[k]   <= zero_top ? lz_sn[k-1] + NSH'(SH) : lz_sn[k-1];
			w1_sn[k]   <= w1_sn[k-1];
			w2_sn[k]   <= w2_sn[k-1];
		end
	end

	assign stat.push = v_sn[NSH];
	assign stat.drop = drop_q;
	assign w1        = w1_sn[NSH];
	assign w2        = w2_sn[NSH];
	assign mant      = norm_sn[NSH][NW-1 -: MANT_W];
	assign expo      = E_W'(lz_sn[NSH] - NSH'(LZ_OFF));

endmodule

### rtl/pgs_queue.sv
module pgs_queue import pgs_pkg::*; #(
	parameter int WIDTH = 2 * (UNIFORM_BITS_DEF + 1) + MANT_W + E_W,
	parameter int DEPTH = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             nonempty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	assign dout     = mem[rd_q];
	assign nonempty = (cnt_q != '0);

endmodule

### rtl/pgs_back.sv
module pgs_back import pgs_pkg::*; #(
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         avail,
	output logic                         pop,
	input  logic signed [UNIFORM_BITS:0] w1,
	input  logic signed [UNIFORM_BITS:0] w2,
	input  logic [MANT_W-1:0]            mant,
	input  logic [E_W-1:0]               expo,
	input  logic signed [MEAN_W-1:0]     mean_offset,
	input  logic [SCALE_W-1:0]           spread_scale,
	output logic                         strobe,
	output logic signed [SAMPLE_W-1:0]   sample_value,
	output logic                         last_of_pair
);
	localparam int UB    = UNIFORM_BITS;
	localparam int LOG_N = FRAC_W;
	localparam int DIV_N = LN_W;
	localparam int PRE   = MANT_W - 1;
	localparam int SQ_N  = ROOT_IN_W / 2;
	localparam int TW    = E_W + FRAC_W;
	localparam int AW    = UB + 1;
	localparam int PW    = AW + R_W;
	localparam int XW    = PW - UB - 1;
	localparam int YW    = XW + SCALE_W;
	localparam int MAGW  = YW + 1 - ROUND_SH;
	localparam int SUMW  = MAGW + 2;
	localparam logic [YW:0] RND = (YW+1)'(1) << (ROUND_SH - 1);
	localparam logic signed [SUMW-1:0] SAT_HI = SUMW'($signed(32'h7fffffff));
	localparam logic signed [SUMW-1:0] SAT_LO = SUMW'($signed(32'h80000000));

	typedef struct packed {
		logic signed [UB:0] w1;
		logic signed [UB:0] w2;
		logic [E_W-1:0]     e;
	} side_t;

	logic pop_q;

	assign pop = avail & ~pop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= 1'b0;
		end else begin
			pop_q <= pop;
		end
	end

	// log2 by repeated squaring
	logic                v_ln   [LOG_N+1];
	logic [MANT_W-1:0]   y_ln   [LOG_N+1];
	logic [FRAC_W-1:0]   f_ln   [LOG_N+1];
	logic [MANT_W-1:0]   m_ln   [LOG_N+1];
	side_t               sd_ln  [LOG_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ln[0] <= 1'b0;
		end else begin
			v_ln[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		y_ln[0]  <= mant;
		f_ln[0]  <= '0;
		m_ln[0]  <= mant;
		sd_ln[0] <= '{w1: w1, w2: w2, e: expo};
	end

	for (genvar k = 0; k < LOG_N; k++) begin : g_log
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     t;
		assign sq = (2*MANT_W)'(y_ln[k]) * (2*MANT_W)'(y_ln[k]);
		assign t  = sq[2*MANT_W-1:MANT_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_ln[k+1] <= 1'b0;
			end else begin
				v_ln[k+1] <= v_ln[k];
			end
		end

		always_ff @(posedge clk) begin
			y_ln[k+1]  <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
			f_ln[k+1]  <= f_ln[k] | ({{(FRAC_W-1){1'b0}}, t[MANT_W]} << (FRAC_W - 1 - k));
			m_ln[k+1]  <= m_ln[k];
			sd_ln[k+1] <= sd_ln[k];
		end
	end

	// natural log scaling
	logic [TW-1:0]       t_full;
	logic                v_n1;
	logic [2*FRAC_W-1:0] tlp_n1;
	logic [E_W-1:0]      th_n1;
	logic [MANT_W-1:0]   m_n1;
	side_t               sd_n1;
	logic [LN_W-2:0]     hsum;
	logic [LN_W-1:0]     nq;

	assign t_full = {sd_ln[LOG_N].e, {FRAC_W{1'b0}}} - TW'(f_ln[LOG_N]);
	assign hsum   = (LN_W-1)'(th_n1) * (LN_W-1)'(LN2_Q32)
	              + (LN_W-1)'(tlp_n1[2*FRAC_W-1:FRAC_W]);
	assign nq     = {hsum, 1'b0};

	// restoring division, one quotient bit a stage
	logic                v_dv  [DIV_N+1];
	logic [MANT_W-1:0]   r_dv  [DIV_N+1];
	logic [LN_W-1:0]     nb_dv [DIV_N+1];
	logic [LN_W-1:0]     q_dv  [DIV_N+1];
	logic [MANT_W-1:0]   m_dv  [DIV_N+1];
	side_t               sd_dv [DIV_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n1    <= 1'b0;
			v_dv[0] <= 1'b0;
		end else begin
			v_n1    <= v_ln[LOG_N];
			v_dv[0] <= v_n1;
		end
	end

	always_ff @(posedge clk) begin
		tlp_n1   <= (2*FRAC_W)'(t_full[FRAC_W-1:0]) * (2*FRAC_W)'(LN2_Q32);
		th_n1    <= t_full[TW-1:FRAC_W];
		m_n1     <= m_ln[LOG_N];
		sd_n1    <= sd_ln[LOG_N];
		r_dv[0]  <= MANT_W'(nq[LN_W-1 -: PRE]);
		nb_dv[0] <= {nq[LN_W-PRE-1:0], {PRE{1'b0}}};
		q_dv[0]  <= '0;
		m_dv[0]  <= m_n1;
		sd_dv[0] <= sd_n1;
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [MANT_W:0] rr;
		logic            ge;
		assign rr = {r_dv[k], nb_dv[k][LN_W-1]};
		assign ge = (rr >= {1'b0, m_dv[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[k+1] <= 1'b0;
			end else begin
				v_dv[k+1] <= v_dv[k];
			end
		end

		always_ff @(posedge clk) begin
			r_dv[k+1]  <= ge ? MANT_W'(rr - {1'b0, m_dv[k]}) : MANT_W'(rr);
			q_dv[k+1]  <= {q_dv[k][LN_W-2:0], ge};
			nb_dv[k+1] <= nb_dv[k] << 1;
			m_dv[k+1]  <= m_dv[k];
			sd_dv[k+1] <= sd_dv[k];
		end
	end

	// square root, one result bit a stage
	logic                 v_rt   [SQ_N+1];
	logic [ROOT_IN_W-1:0] x_rt   [SQ_N+1];
	logic [ROOT_IN_W-1:0] res_rt [SQ_N+1];
	side_t                sd_rt  [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rt[0] <= 1'b0;
		end else begin
			v_rt[0] <= v_dv[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		x_rt[0]   <= ROOT_IN_W'({q_dv[DIV_N], {ROOT_SH{1'b0}}}) << sd_dv[DIV_N].e[0];
		res_rt[0] <= '0;
		sd_rt[0]  <= sd_dv[DIV_N];
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_root
		localparam logic [ROOT_IN_W-1:0] BIT = ROOT_IN_W'(1) << (ROOT_IN_W - 2 - 2 * k);
		logic [ROOT_IN_W-1:0] trial;
		logic                 ge;
		assign trial = res_rt[k] + BIT;
		assign ge    = (x_rt[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_rt[k+1] <= 1'b0;
			end else begin
				v_rt[k+1] <= v_rt[k];
			end
		end

		always_ff @(posedge clk) begin
			x_rt[k+1]   <= ge ? x_rt[k] - trial : x_rt[k];
			res_rt[k+1] <= ge ? (res_rt[k] >> 1) + BIT : res_rt[k] >> 1;
			sd_rt[k+1]  <= sd_rt[k];
		end
	end

	// two samples per pair, one a cycle through the output stages
	logic               root_v;
	logic [R_W-1:0]     root_r;
	logic [E_W-2:0]     root_h;
	logic               hold_v_q;
	logic signed [UB:0] hold_w_q;
	logic [R_W-1:0]     hold_r_q;
	logic [E_W-2:0]     hold_h_q;
	logic               fin_v, fin_last;
	logic signed [UB:0] fin_w;
	logic [R_W-1:0]     fin_r;
	logic [E_W-2:0]     fin_h;
	logic [UB-1:0]      fin_mag;

	assign root_v   = v_rt[SQ_N];
	assign root_r   = res_rt[SQ_N][R_W-1:0];
	assign root_h   = sd_rt[SQ_N].e[E_W-1:1];
	assign fin_v    = root_v | hold_v_q;
	assign fin_last = ~root_v;
	assign fin_w    = root_v ? sd_rt[SQ_N].w1 : hold_w_q;
	assign fin_r    = root_v ? root_r : hold_r_q;
	assign fin_h    = root_v ? root_h : hold_h_q;
	assign fin_mag  = fin_w[UB] ? UB'(-fin_w) : UB'(fin_w);

	logic               v_f1, v_f2, v_f3, v_f4;
	logic [AW-1:0]      a_f1;
	logic [R_W-1:0]     r_f1;
	logic               neg_f1, neg_f2, neg_f3, neg_f4;
	logic               last_f1, last_f2, last_f3, last_f4;
	logic [PW-1:0]      p_f2;
	logic [YW-1:0]      y_f3;
	logic [MAGW-1:0]    mag_f4;
	logic [YW:0]        rnd;
	logic signed [SUMW-1:0] sv, tot, sat;

	assign rnd = {1'b0, y_f3} + RND;

	always_comb begin
		sv = $signed({2'b00, mag_f4});
		if (neg_f4) begin
			sv = -sv;
		end
		tot = sv + SUMW'(mean_offset);
		if (tot > SAT_HI) begin
			sat = SAT_HI;
		end else if (tot < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			v_f1     <= 1'b0;
			v_f2     <= 1'b0;
			v_f3     <= 1'b0;
			v_f4     <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			hold_v_q <= root_v;
			v_f1     <= fin_v;
			v_f2     <= v_f1;
			v_f3     <= v_f2;
			v_f4     <= v_f3;
			strobe   <= v_f4;
		end
	end

	always_ff @(posedge clk) begin
		hold_w_q     <= sd_rt[SQ_N].w2;
		hold_r_q     <= root_r;
		hold_h_q     <= root_h;
		a_f1         <= AW'(fin_mag) << fin_h;
		r_f1         <= fin_r;
		neg_f1       <= fin_w[UB];
		last_f1      <= fin_last;
		p_f2         <= PW'(a_f1) * PW'(r_f1);
		neg_f2       <= neg_f1;
		last_f2      <= last_f1;
		y_f3         <= YW'(p_f2[PW-1:UB+1]) * YW'(spread_scale);
		neg_f3       <= neg_f2;
		last_f3      <= last_f2;
		mag_f4       <= rnd[YW:ROUND_SH];
		neg_f4       <= neg_f3;
		last_f4      <= last_f3;
		sample_value <= SAMPLE_W'(sat);
		last_of_pair <= last_f4;
	end

endmodule

### rtl/polar_gaussian_sample_top.sv
// Polar Gaussian sample generator.
// Input: a pair of uniform samples on uniform_first / uniform_second is
// transferred at a rising edge with start high and busy low. A pair inside
// the unit circle and off its centre yields two results; others yield none.
// Output: each result sits on sample_value / last_of_pair for one cycle with
// strobe high; the first sample has last_of_pair low, the second high, in
// back to back cycles. The receiver cannot stall the block.
// Config: cfg_valid / cfg_ready write port, cfg_index 0 is mean_offset and
// 1 is spread_scale; cfg_ready is always high. Write only while idle.
// The back holds the 32-step log, 41-step divide and 31-step root chains.
// Throughput: one pair a cycle while pairs are rejected; kept pairs are
// paced by the single output port, which gives out a pair's two samples in
// turn. busy rises when queue slots are all taken by pairs in flight.
// Reset clears the pipelines and queue and loads mean 0, spread 1.0.
module polar_gaussian_sample_top import pgs_pkg::*; #(
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [UNIFORM_BITS-1:0]     uniform_first,
	input  logic [UNIFORM_BITS-1:0]     uniform_second,
	output logic                        strobe,
	output logic signed [SAMPLE_W-1:0]  sample_value,
	output logic                        last_of_pair,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);
	localparam int UB        = UNIFORM_BITS;
	localparam int NW        = (2 * UB > MANT_W) ? 2 * UB : MANT_W;
	localparam int FRONT_LAT = 3 + $clog2(NW);
	localparam int QDEPTH    = FRONT_LAT + 4;
	localparam int RSW       = $clog2(QDEPTH + 1);
	localparam int QW        = 2 * (UB + 1) + MANT_W + E_W;

	logic signed [MEAN_W-1:0] mean_q;
	logic [SCALE_W-1:0]       spread_q;
	logic [RSW-1:0]           resv_q;
	logic                     take, pop, avail;
	front_stat_t              fstat;
	logic signed [UB:0]       fw1, fw2, bw1, bw2;
	logic [MANT_W-1:0]        fmant, bmant;
	logic [E_W-1:0]           fexpo, bexpo;
	logic [QW-1:0]            qout;

	assign cfg_ready = 1'b1;
	assign busy      = (resv_q >= RSW'(QDEPTH));
	assign take      = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= MEAN_RESET;
			spread_q <= SCALE_RESET;
			resv_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MEAN_OFFSET:  mean_q   <= $signed(cfg_data[MEAN_W-1:0]);
					CFG_SPREAD_SCALE: spread_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			resv_q <= resv_q + RSW'(take) - RSW'(fstat.drop) - RSW'(pop);
		end
	end

	pgs_front #(.UNIFORM_BITS(UB)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.uniform_first  (uniform_first),
		.uniform_second (uniform_second),
		.stat           (fstat),
		.w1             (fw1),
		.w2             (fw2),
		.mant           (fmant),
		.expo           (fexpo)
	);

	pgs_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fstat.push),
		.din      ({fw1, fw2, fmant, fexpo}),
		.pop      (pop),
		.dout     (qout),
		.nonempty (avail)
	);

	assign bw1   = $signed(qout[QW-1 -: UB+1]);
	assign bw2   = $signed(qout[QW-UB-2 -: UB+1]);
	assign bmant = qout[MANT_W+E_W-1:E_W];
	assign bexpo = qout[E_W-1:0];

	pgs_back #(.UNIFORM_BITS(UB)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.pop          (pop),
		.w1           (bw1),
		.w2           (bw2),
		.mant         (bmant),
		.expo         (bexpo),
		.mean_offset  (mean_q),
		.spread_scale (spread_q),
		.strobe       (strobe),
		.sample_value (sample_value),
		.last_of_pair (last_of_pair)
	);

endmodule
